FILE: rtl/sfr_pkg.sv
package sfr_pkg;

   // Result kinds as they appear on the response channel.
   typedef enum logic [2:0] {
      KIND_FW_VERSION    = 3'd0,
      KIND_RAIN_STATUS   = 3'd1,
      KIND_SENSOR_STATUS = 3'd2,
      KIND_OPTICS        = 3'd3,
      KIND_REALTIME_RAIN = 3'd4,
      KIND_UNKNOWN       = 3'd5,
      KIND_CRC_ERROR     = 3'd6
   } kind_type;

   // Function indexes carried in the low seven bits of the flags byte.
   localparam logic [6:0] IDX_FW_VERSION    = 7'd0;
   localparam logic [6:0] IDX_RAIN_STATUS   = 7'd1;
   localparam logic [6:0] IDX_SENSOR_STATUS = 7'd2;
   localparam logic [6:0] IDX_OPTICS        = 7'd3;
   localparam logic [6:0] IDX_REALTIME_RAIN = 7'd4;

   localparam logic [7:0] START_BYTE = 8'h3A;
   localparam logic [7:0] CRC_POLY   = 8'h31;
   localparam logic [7:0] CRC_INIT   = 8'hFF;

   // Rain percent is (value * 3333 + 49) / 100. The division is done as a
   // shift by two and a reciprocal multiply for the remaining divide by 25,
   // exact for every dividend below 2^26.
   localparam logic [11:0] RAIN_SCALE  = 12'd3333;
   localparam logic [27:0] RAIN_BIAS   = 28'd49;
   localparam logic [26:0] DIV25_RECIP = 27'd85899346;
   localparam int          DIV25_SHIFT = 31;

   // A completed, well-led frame waiting to be decoded.
   typedef struct packed {
      logic [6:0]  index;
      logic [15:0] value;
      logic        crc_ok;
      logic [31:0] time_ms;
   } frame_type;

   // Outcome of decoding one frame.
   typedef struct packed {
      logic        keep;
      logic        take_realtime;
      kind_type    kind;
      logic [6:0]  index;
      logic [15:0] value;
      logic [27:0] product;
      logic [7:0]  version_major;
      logic [7:0]  version_minor;
   } decode_type;

   // One byte of CRC-8, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/sfr_decode.sv
module sfr_decode
   import sfr_pkg::*;
(
   input  frame_type   frame,
   input  logic [31:0] last_realtime_ms,
   input  logic [15:0] throttle_ms,
   output decode_type  result
);

   logic [31:0] elapsed;
   logic        pass;
   kind_type    kind;

   assign elapsed = frame.time_ms - last_realtime_ms;
   assign pass    = elapsed >= {16'd0, throttle_ms};

   always_comb begin
      if (!frame.crc_ok) begin
         kind = KIND_CRC_ERROR;
      end else begin
         case (frame.index)
            IDX_FW_VERSION:    kind = KIND_FW_VERSION;
            IDX_RAIN_STATUS:   kind = KIND_RAIN_STATUS;
            IDX_SENSOR_STATUS: kind = KIND_SENSOR_STATUS;
            IDX_OPTICS:        kind = KIND_OPTICS;
            IDX_REALTIME_RAIN: kind = KIND_REALTIME_RAIN;
            default:           kind = KIND_UNKNOWN;
         endcase
      end
   end

   always_comb begin
      result               = '0;
      result.kind          = kind;
      result.index         = frame.index;
      result.value         = frame.value;
      result.take_realtime = (kind == KIND_REALTIME_RAIN) && pass;
      result.keep          = (kind != KIND_REALTIME_RAIN) || pass;
      if (kind == KIND_RAIN_STATUS) begin
         result.product = ({12'd0, frame.value} * {16'd0, RAIN_SCALE}) + RAIN_BIAS;
      end
      if (kind == KIND_FW_VERSION) begin
         result.version_major = frame.value[15:8];
         result.version_minor = frame.value[7:0];
      end
   end

endmodule

FILE: rtl/sensor_frame_receiver_crc8_unit.sv
// Sensor frame receiver. Each request item is either a received UART byte
// (req_action = 0) or a one-millisecond tick (req_action = 1). A start byte
// of 0x3A restarts a five-byte frame: start, flags, value low, value high,
// CRC. The CRC-8 (polynomial 0x31, initial value 0xFF, MSB first) is
// updated one byte at a time as bytes arrive, so a completed frame only
// needs a compare. A frame not led by 0x3A, or one with a zero flags byte,
// is dropped silently. A good frame is classified by its function index
// (flags AND 0x7F) and gives one response item; a CRC mismatch gives a
// crc error item. Realtime rain reports (index 4) closer together than
// csr_wdata milliseconds, as last written with csr_we, are dropped. The
// block accepts one item every cycle unless a stall from rsp_ready holds
// it back. A frame that gives a response goes through three register
// stages (capture, decode, rain divide) before its response appears;
// ticks and other bytes give no response. The rain percent divide by 100
// is a shift and a reciprocal multiply in the last stage.
module sensor_frame_receiver_crc8_unit
   import sfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [6:0]  rsp_function_index,
   output logic [15:0] rsp_value,
   output logic [21:0] rsp_rain_percent,
   output logic [7:0]  rsp_version_major,
   output logic [7:0]  rsp_version_minor,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   // Frame collection state.
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  byte0_ff, byte0_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;
   logic [7:0]  crc_ff, crc_in;
   logic [31:0] time_ff, time_in;
   logic [31:0] last_rt_ff, last_rt_in;
   logic [15:0] throttle_ff, throttle_in;

   // Pipeline stages.
   logic        s1_valid_ff, s1_valid_in;
   frame_type   s1_ff, s1_in;
   logic        s2_valid_ff, s2_valid_in;
   decode_type  s2_ff, s2_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [6:0]  index_ff, index_in;
   logic [15:0] value_ff, value_in;
   logic [21:0] rain_ff, rain_in;
   logic [7:0]  major_ff, major_in;
   logic [7:0]  minor_ff, minor_in;

   logic        accept;
   logic        is_byte;
   logic [2:0]  pos_eff;
   logic        complete;
   logic        out_free;
   logic        s2_free;
   logic        s1_free;
   decode_type  dec;
   logic [52:0] rain_full;

   // Stalls ripple back from the response register.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;
   assign is_byte   = accept && !req_action;

   always_comb begin
      if (req_rx_byte == START_BYTE || pos_ff > 3'd4) begin
         pos_eff = 3'd0;
      end else begin
         pos_eff = pos_ff;
      end
   end

   assign complete = is_byte && (pos_eff == 3'd4);

   // Byte collection, CRC and the millisecond clock.
   always_comb begin
      pos_in      = pos_ff;
      byte0_in    = byte0_ff;
      flags_in    = flags_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      crc_in      = crc_ff;
      time_in     = time_ff;
      throttle_in = csr_we ? csr_wdata : throttle_ff;
      s1_in       = s1_ff;
      if (accept && req_action) begin
         time_in = time_ff + 32'd1;
      end
      if (is_byte) begin
         pos_in = complete ? 3'd0 : pos_eff + 3'd1;
         case (pos_eff)
            3'd0: byte0_in = req_rx_byte;
            3'd1: begin
               flags_in = req_rx_byte;
               crc_in   = crc8_byte(CRC_INIT, req_rx_byte);
            end
            3'd2: begin
               lo_in  = req_rx_byte;
               crc_in = crc8_byte(crc_ff, req_rx_byte);
            end
            3'd3: begin
               hi_in  = req_rx_byte;
               crc_in = crc8_byte(crc_ff, req_rx_byte);
            end
            default: begin
               // Last byte: it is the CRC, so capture the frame for decode.
               s1_in.index   = flags_ff[6:0];
               s1_in.value   = {hi_ff, lo_ff};
               s1_in.crc_ok  = (crc_ff == req_rx_byte);
               s1_in.time_ms = time_ff;
            end
         endcase
      end
   end

   // Only frames led by the start byte with a nonzero flags byte go on.
   always_comb begin
      if (complete && byte0_ff == START_BYTE && flags_ff != 8'd0) begin
         s1_valid_in = 1'b1;
      end else if (s2_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   sfr_decode u_decode (
      .frame            (s1_ff),
      .last_realtime_ms (last_rt_ff),
      .throttle_ms      (throttle_ff),
      .result           (dec)
   );

   // Decode stage; the realtime timestamp moves only when a report passes.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      last_rt_in  = last_rt_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff && dec.keep;
         s2_in       = dec;
         if (s1_valid_ff && dec.take_realtime) begin
            last_rt_in = s1_ff.time_ms;
         end
      end
   end

   // Rain stage: divide by 4 with a shift, then by 25 with a reciprocal.
   assign rain_full = {1'b0, s2_ff.product[27:2]} * {26'd0, DIV25_RECIP};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      rain_in      = rain_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      if (out_free) begin
         rsp_valid_in = s2_valid_ff;
         kind_in      = s2_ff.kind;
         index_in     = s2_ff.index;
         value_in     = s2_ff.value;
         rain_in      = rain_full[DIV25_SHIFT +: 22];
         major_in     = s2_ff.version_major;
         minor_in     = s2_ff.version_minor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         time_ff      <= 32'd0;
         last_rt_ff   <= 32'd0;
         throttle_ff  <= 16'd0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         time_ff      <= time_in;
         last_rt_ff   <= last_rt_in;
         throttle_ff  <= throttle_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Frame bytes are always written before they are read, so no reset.
   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      flags_ff <= flags_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      crc_ff   <= crc_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      kind_ff  <= kind_in;
      index_ff <= index_in;
      value_ff <= value_in;
      rain_ff  <= rain_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_function_index = index_ff;
   assign rsp_value          = value_ff;
   assign rsp_rain_percent   = rain_ff;
   assign rsp_version_major  = major_ff;
   assign rsp_version_minor  = minor_ff;

endmodule
